@@ sv/ofs_pkg.sv @@
// Shared types and constants for the overlapping frame segmenter.
// No dependencies; imported by overlapping_frame_segmenter_top.
`timescale 1ns / 1ps

package ofs_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int POS_W     = 10;
  localparam int FLEN_W    = 11;
  localparam int TOT_W     = 32;
  localparam int PAD_W     = 12;
  localparam int POS_LIMIT = 1024;

  // operation codes
  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_PULL    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_READY = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NO_FRAMES = 3'd3;
  localparam logic [2:0] ST_BAD_CFG   = 3'd4;
  localparam logic [2:0] ST_EXCESS    = 3'd5;

  // register indexes
  localparam logic [1:0] REG_FRAME_LENGTH = 2'd0;
  localparam logic [1:0] REG_HOP_LENGTH   = 2'd1;
  localparam logic [1:0] REG_TOTAL_LENGTH = 2'd2;

  typedef struct packed {
    logic [1:0]                 operation;
    logic signed [SAMPLE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                 status;
    logic signed [SAMPLE_W-1:0] out_sample;
    logic [TOT_W-1:0]           frame_number;
    logic [POS_W-1:0]           position;
    logic                       last_of_frame;
  } out_item_t;

  // smallest power of two not below n; zero for n == 0
  function automatic logic [PAD_W-1:0] pad_size(input logic [FLEN_W-1:0] n);
    logic [FLEN_W-1:0] m;
    logic [PAD_W-1:0]  p;
    m = n - FLEN_W'(1);
    p = PAD_W'(1);
    for (int i = 0; i < FLEN_W; i++) begin
      if (m[i]) p = PAD_W'(2) << i;
    end
    if (n == '0) p = '0;
    return p;
  endfunction

endpackage

@@ sv/overlapping_frame_segmenter_top.sv @@
// Overlapping frame segmenter: each input transaction passes through stage 1 and the output register.
// Throughput one transaction per cycle unless out_stall back-pressure raises in_stall; the single-port-per-side
// sample ring memory takes at most one write (push) or one read (pull) per transaction.
// Reset (rst_n low, synchronous) clears counts, pointers and pipeline valids and loads
// frame_length 400, hop_length 200, total_length 4294967295. Ring contents are not cleared.
// Depends on ofs_pkg.
`timescale 1ns / 1ps

module overlapping_frame_segmenter_top
  import ofs_pkg::*;
#(
  parameter int MAX_FRAME  = 1024,
  parameter int RING_DEPTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [TOT_W-1:0] cfg_wdata
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int AW    = PTR_W + 1;

  // configuration
  logic [FLEN_W-1:0] frame_len_r, hop_len_r;
  logic [PAD_W-1:0]  pad_r;
  logic [TOT_W-1:0]  total_len_r;

  // stream state
  logic [TOT_W-1:0]  sw_r, sw_nxt;
  logic [TOT_W-1:0]  fs_r, fs_nxt;
  logic [TOT_W-1:0]  fc_r, fc_nxt;
  logic [POS_W-1:0]  offset_r, offset_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  fs_ptr_r, fs_ptr_nxt;

  // sample ring
  logic [SAMPLE_W-1:0] ring [RING_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [PTR_W-1:0]    rd_addr;
  logic                rd_en, wr_en;

  // pipeline
  logic      s1_v_r, s1_use_rd_r;
  out_item_t s1_res_r;
  out_item_t s1_out;
  logic      out_v_r;
  out_item_t out_res_r;
  logic      s1_go, acc;

  out_item_t res;
  logic      cfg_bad, buf_full, not_ready, in_range, is_last;
  logic [TOT_W-1:0] held;
  logic [TOT_W:0]   need_raw, need, at_full, fs_hop;
  logic [AW-1:0]    rd_sum, fs_sum;

  assign s1_go    = s1_v_r && (!out_v_r || !out_stall);
  assign in_stall = s1_v_r && out_v_r && out_stall;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    cfg_bad = (frame_len_r == '0) || (hop_len_r == '0) || (total_len_r == '0) ||
              (hop_len_r > frame_len_r) ||
              (32'(frame_len_r) > 32'(MAX_FRAME)) ||
              (32'(frame_len_r) > 32'(RING_DEPTH)) ||
              (32'(pad_r) > 32'(POS_LIMIT));

    held     = (sw_r > fs_r) ? (sw_r - fs_r) : '0;
    buf_full = held >= 32'(RING_DEPTH);

    need_raw  = {1'b0, fs_r} + (TOT_W+1)'(frame_len_r);
    need      = (need_raw > {1'b0, total_len_r}) ? {1'b0, total_len_r} : need_raw;
    not_ready = {1'b0, sw_r} < need;

    at_full  = {1'b0, fs_r} + (TOT_W+1)'(offset_r);
    in_range = (FLEN_W'(offset_r) < frame_len_r) && (at_full < {1'b0, total_len_r});
    is_last  = (PAD_W'(offset_r) + PAD_W'(1)) >= pad_r;

    // ring index of the pulled sample; offset < frame_length <= depth when read
    rd_sum  = AW'(fs_ptr_r) + AW'(offset_r);
    rd_addr = (rd_sum >= AW'(RING_DEPTH)) ? PTR_W'(rd_sum - AW'(RING_DEPTH))
                                          : PTR_W'(rd_sum);
    fs_sum  = AW'(fs_ptr_r) + AW'(hop_len_r);
    fs_hop  = {1'b0, fs_r} + (TOT_W+1)'(hop_len_r);

    res.status        = ST_OK;
    res.out_sample    = '0;
    res.frame_number  = fc_r;
    res.position      = offset_r;
    res.last_of_frame = 1'b0;

    sw_nxt     = sw_r;
    fs_nxt     = fs_r;
    fc_nxt     = fc_r;
    offset_nxt = offset_r;
    wr_ptr_nxt = wr_ptr_r;
    fs_ptr_nxt = fs_ptr_r;
    rd_en      = 1'b0;
    wr_en      = 1'b0;

    case (in_data.operation)
      OP_RESTART: begin
        // the answer reports the cleared counts
        res.frame_number = '0;
        res.position     = '0;
        sw_nxt     = '0;
        fs_nxt     = '0;
        fc_nxt     = '0;
        offset_nxt = '0;
        wr_ptr_nxt = '0;
        fs_ptr_nxt = '0;
      end
      OP_PUSH: begin
        if (cfg_bad) begin
          res.status = ST_BAD_CFG;
        end else if (sw_r >= total_len_r) begin
          res.status = ST_EXCESS;
        end else if (buf_full) begin
          res.status = ST_FULL;
        end else begin
          wr_en      = 1'b1;
          sw_nxt     = sw_r + 32'd1;
          wr_ptr_nxt = (wr_ptr_r == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
        end
      end
      OP_PULL: begin
        if (cfg_bad) begin
          res.status = ST_BAD_CFG;
        end else if (fs_r >= total_len_r) begin
          res.status = ST_NO_FRAMES;
        end else if (not_ready) begin
          res.status = ST_NOT_READY;
        end else begin
          rd_en             = in_range;
          res.last_of_frame = is_last;
          if (is_last) begin
            offset_nxt = '0;
            fc_nxt     = fc_r + 32'd1;
            // saturated start is not below any total_length, so the ring pointer goes stale harmlessly
            fs_nxt     = fs_hop[TOT_W] ? '1 : fs_hop[TOT_W-1:0];
            fs_ptr_nxt = (fs_sum >= AW'(RING_DEPTH)) ? PTR_W'(fs_sum - AW'(RING_DEPTH))
                                                     : PTR_W'(fs_sum);
          end else begin
            offset_nxt = offset_r + POS_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= FLEN_W'(400);
      pad_r       <= PAD_W'(512);
      hop_len_r   <= FLEN_W'(200);
      total_len_r <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_LENGTH: begin
          frame_len_r <= cfg_wdata[FLEN_W-1:0];
          pad_r       <= pad_size(cfg_wdata[FLEN_W-1:0]);
        end
        REG_HOP_LENGTH:   hop_len_r   <= cfg_wdata[FLEN_W-1:0];
        REG_TOTAL_LENGTH: total_len_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r     <= '0;
      fs_r     <= '0;
      fc_r     <= '0;
      offset_r <= '0;
      wr_ptr_r <= '0;
      fs_ptr_r <= '0;
    end else if (acc) begin
      sw_r     <= sw_nxt;
      fs_r     <= fs_nxt;
      fc_r     <= fc_nxt;
      offset_r <= offset_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fs_ptr_r <= fs_ptr_nxt;
    end
  end

  // ring memory: push writes at the write pointer, pull reads into a register alongside stage 1
  always_ff @(posedge clk) begin
    if (acc && wr_en) ring[wr_ptr_r] <= in_data.sample_value;
  end

  always_ff @(posedge clk) begin
    if (acc && rd_en) rd_data_r <= ring[rd_addr];
  end

  // stage 1 waits on read data; read data holds while stage 1 stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res_r    <= res;
      s1_use_rd_r <= rd_en;
    end
  end

  always_comb begin
    s1_out            = s1_res_r;
    s1_out.out_sample = s1_use_rd_r ? rd_data_r : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_res_r <= s1_out;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_res_r;

`ifndef SYNTH
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && out_v_r))
    else $error("input stalled with free pipeline slot");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_go && !acc) |=> (s1_v_r && $stable(s1_res_r) && $stable(rd_data_r)))
    else $error("stage 1 transaction lost while stalled");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (sw_r > fs_r) |-> ((sw_r - fs_r) <= 32'(RING_DEPTH)))
    else $error("ring holds more samples than its depth");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(wr_ptr_r) < 32'(RING_DEPTH)) && (32'(fs_ptr_r) < 32'(RING_DEPTH)))
    else $error("ring pointer out of range");
`endif

endmodule
